// ----- sv/sdt_pkg.sv -----
// Package for the surface damage tracker: sizes, request and status codes,
// the entry record type and the FNV-1a byte fold. Depends on nothing.
`default_nettype none

package sdt_pkg;

  localparam int SURFACES = 16;
  localparam int MAX_DIM = 4096;
  localparam int IDX_W = (SURFACES > 1) ? $clog2(SURFACES) : 1;

  localparam int TYPE_W = 2;
  localparam int ID_W = 4;
  localparam int DIM_W = 13;
  localparam int COLOR_W = 32;
  localparam int STATUS_W = 3;
  localparam int HASH_W = 32;
  localparam int COUNT_W = 32;

  localparam logic [HASH_W-1:0] FNV_BASIS = 32'h811C_9DC5;
  localparam logic [HASH_W-1:0] FNV_PRIME = 32'h0100_0193;

  localparam logic [TYPE_W-1:0] REQ_CREATE = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_DAMAGE = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_PRESENT = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_BAD_SIZE = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_BAD_ID = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_OUTSIDE = 3'd4;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [DIM_W-1:0]   size_w;
    logic [DIM_W-1:0]   size_h;
    logic [DIM_W-1:0]   x0;
    logic [DIM_W-1:0]   y0;
    logic [DIM_W-1:0]   x1;
    logic [DIM_W-1:0]   y1;
  } entry_t;

  // One FNV-1a step: XOR in a byte, then multiply by the prime modulo 2^32.
  function automatic logic [HASH_W-1:0] fold_byte(input logic [HASH_W-1:0] h,
                                                  input logic [7:0] b);
    logic [HASH_W-1:0] mixed;
    mixed = h ^ {24'd0, b};
    return mixed * FNV_PRIME;
  endfunction

endpackage

`default_nettype wire

// ----- sv/sdt_ifs.sv -----
// Valid/ready channel interfaces for the surface damage tracker: the request
// channel and the response channel. Depends on sdt_pkg.
`default_nettype none

interface sdt_req_if;
  logic                          valid;
  logic                          ready;
  logic [sdt_pkg::TYPE_W-1:0]    req_type;
  logic [sdt_pkg::ID_W-1:0]      surf_id;
  logic [sdt_pkg::DIM_W-1:0]     pos_x;
  logic [sdt_pkg::DIM_W-1:0]     pos_y;
  logic [sdt_pkg::DIM_W-1:0]     width;
  logic [sdt_pkg::DIM_W-1:0]     height;
  logic [sdt_pkg::COLOR_W-1:0]   color;

  modport source (output valid, req_type, surf_id, pos_x, pos_y, width, height, color,
                  input ready);
  modport sink (input valid, req_type, surf_id, pos_x, pos_y, width, height, color,
                output ready);
endinterface

interface sdt_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [sdt_pkg::STATUS_W-1:0]  status;
  logic [sdt_pkg::ID_W-1:0]      new_index;
  logic [sdt_pkg::HASH_W-1:0]    frame_hash;
  logic [sdt_pkg::COUNT_W-1:0]   frame_count;

  modport source (output valid, status, new_index, frame_hash, frame_count,
                  input ready);
  modport sink (input valid, status, new_index, frame_hash, frame_count,
                output ready);
endinterface

`default_nettype wire

// ----- sv/surface_damage_tracker.sv -----
// Surface damage tracker top level: surface table in a synchronous memory,
// used/dirty flags, request sequencer and response register.
// Depends on sdt_pkg and the interfaces in sdt_ifs.sv.
//
// Usage: requests arrive on the req channel (valid/ready); one response
// transaction per request leaves on the rsp channel. A create takes the
// lowest free entry, a damage request clips and merges a rectangle into an
// entry, and a present hashes all dirty entries in index order and bumps the
// wrapping frame counter that every response reports.
// The block works on one request at a time. An unknown request goes straight
// to the response register; a create passes through the create state; a
// damage request checks the id while the table memory read runs, then merges
// the rectangle (a refused id skips the merge); a present visits every entry
// in index order and, for a dirty one, reads, checks, then runs four FNV
// rounds through one 32x32 multiplier. req.ready is high whenever the sequencer
// is idle, even while a finished response still waits in the output register;
// a stalled receiver holds only the final hand-off of the next response.
// Reset (synchronous, active high) clears the used and dirty flags, the
// frame counter and the handshake state. The record memory is not cleared:
// an entry is always written by its create before it is used.
`default_nettype none

module surface_damage_tracker (
  input  logic            clk,
  input  logic            rst,
  sdt_req_if.sink         req,
  sdt_rsp_if.source       rsp
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CRT   = 3'd1;
  localparam logic [2:0] S_DCHK  = 3'd2;
  localparam logic [2:0] S_DUPD  = 3'd3;
  localparam logic [2:0] S_PRD   = 3'd4;
  localparam logic [2:0] S_PCHK  = 3'd5;
  localparam logic [2:0] S_PFOLD = 3'd6;
  localparam logic [2:0] S_DONE  = 3'd7;

  // Control state.
  logic [2:0]                          state;
  logic [sdt_pkg::SURFACES-1:0]        used;
  logic [sdt_pkg::SURFACES-1:0]        dirty;
  logic [sdt_pkg::COUNT_W-1:0]         counter;
  logic                                out_valid;

  // Latched request.
  logic [sdt_pkg::TYPE_W-1:0]          op;
  logic [sdt_pkg::ID_W-1:0]            in_id;
  logic [sdt_pkg::DIM_W-1:0]           in_x;
  logic [sdt_pkg::DIM_W-1:0]           in_y;
  logic [sdt_pkg::DIM_W-1:0]           in_w;
  logic [sdt_pkg::DIM_W-1:0]           in_h;
  logic [sdt_pkg::COLOR_W-1:0]         in_color;

  // Working registers and pending result.
  logic [sdt_pkg::IDX_W-1:0]           scan;
  logic [1:0]                          fold_cnt;
  logic [sdt_pkg::HASH_W-1:0]          hash;
  logic [sdt_pkg::COLOR_W-1:0]         fold_word;
  logic [sdt_pkg::STATUS_W-1:0]        res_status;
  logic [sdt_pkg::ID_W-1:0]            res_index;

  // Output register.
  logic [sdt_pkg::STATUS_W-1:0]        out_status;
  logic [sdt_pkg::ID_W-1:0]            out_index;
  logic [sdt_pkg::HASH_W-1:0]          out_hash;
  logic [sdt_pkg::COUNT_W-1:0]         out_count;

  // Surface record memory: one write port, one registered read port.
  sdt_pkg::entry_t                     mem [sdt_pkg::SURFACES];
  sdt_pkg::entry_t                     rd_data;
  sdt_pkg::entry_t                     wr_data;
  logic [sdt_pkg::IDX_W-1:0]           rd_addr;
  logic [sdt_pkg::IDX_W-1:0]           wr_addr;
  logic                                wr_en;

  // Combinational helpers.
  logic                                free_found;
  logic [sdt_pkg::IDX_W-1:0]           free_idx;
  logic [sdt_pkg::IDX_W-1:0]           id_idx;
  logic                                id_ok;
  logic                                size_bad;
  logic                                scan_last;
  logic                                out_free;
  logic [sdt_pkg::DIM_W:0]             ex_sum;
  logic [sdt_pkg::DIM_W:0]             ey_sum;
  logic [sdt_pkg::DIM_W-1:0]           ex;
  logic [sdt_pkg::DIM_W-1:0]           ey;
  logic [sdt_pkg::COLOR_W-1:0]         dmg_w;
  logic [sdt_pkg::COLOR_W-1:0]         dmg_h;

  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.new_index   = out_index;
  assign rsp.frame_hash  = out_hash;
  assign rsp.frame_count = out_count;

  assign out_free  = !out_valid || rsp.ready;
  assign id_idx    = sdt_pkg::IDX_W'(in_id);
  assign id_ok     = (int'(in_id) < sdt_pkg::SURFACES) && used[id_idx];
  assign size_bad  = (in_w == '0) || (in_h == '0) ||
                     (int'(in_w) > sdt_pkg::MAX_DIM) || (int'(in_h) > sdt_pkg::MAX_DIM);
  assign scan_last = (scan == sdt_pkg::IDX_W'(sdt_pkg::SURFACES - 1));
  assign rd_addr   = (state == S_DCHK) ? id_idx : scan;

  // Lowest free entry.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = sdt_pkg::SURFACES - 1; i >= 0; i--) begin
      if (!used[i]) begin
        free_found = 1'b1;
        free_idx   = sdt_pkg::IDX_W'(i);
      end
    end
  end

  // Damage clipping against the surface read from the table.
  always_comb begin
    ex_sum = {1'b0, in_x} + {1'b0, in_w};
    ey_sum = {1'b0, in_y} + {1'b0, in_h};
    ex = (ex_sum > {1'b0, rd_data.size_w}) ? rd_data.size_w : ex_sum[sdt_pkg::DIM_W-1:0];
    ey = (ey_sum > {1'b0, rd_data.size_h}) ? rd_data.size_h : ey_sum[sdt_pkg::DIM_W-1:0];
  end

  // Damage extents of the entry being hashed, as 32-bit differences.
  assign dmg_w = sdt_pkg::COLOR_W'(rd_data.x1) - sdt_pkg::COLOR_W'(rd_data.x0);
  assign dmg_h = sdt_pkg::COLOR_W'(rd_data.y1) - sdt_pkg::COLOR_W'(rd_data.y0);

  // Write port of the record memory.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = free_idx;
    wr_data = rd_data;
    case (state)
      S_CRT: begin
        wr_en          = !size_bad && free_found;
        wr_addr        = free_idx;
        wr_data.color  = in_color;
        wr_data.size_w = in_w;
        wr_data.size_h = in_h;
        wr_data.x0     = '0;
        wr_data.y0     = '0;
        wr_data.x1     = in_w;
        wr_data.y1     = in_h;
      end
      S_DUPD: begin
        wr_en   = (in_x < rd_data.size_w) && (in_y < rd_data.size_h);
        wr_addr = id_idx;
        if (!dirty[id_idx]) begin
          wr_data.x0 = in_x;
          wr_data.y0 = in_y;
          wr_data.x1 = ex;
          wr_data.y1 = ey;
        end else begin
          wr_data.x0 = (in_x < rd_data.x0) ? in_x : rd_data.x0;
          wr_data.y0 = (in_y < rd_data.y0) ? in_y : rd_data.y0;
          wr_data.x1 = (ex > rd_data.x1) ? ex : rd_data.x1;
          wr_data.y1 = (ey > rd_data.y1) ? ey : rd_data.y1;
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Request sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      dirty     <= '0;
      counter   <= '0;
      out_valid <= 1'b0;
    end else begin
      // In S_DONE the output register is refilled in the same cycle it drains.
      if (out_valid && rsp.ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            op         <= req.req_type;
            in_id      <= req.surf_id;
            in_x       <= req.pos_x;
            in_y       <= req.pos_y;
            in_w       <= req.width;
            in_h       <= req.height;
            in_color   <= req.color;
            res_status <= sdt_pkg::STAT_OK;
            res_index  <= '0;
            scan       <= '0;
            hash       <= sdt_pkg::FNV_BASIS;
            case (req.req_type)
              sdt_pkg::REQ_CREATE:  state <= S_CRT;
              sdt_pkg::REQ_DAMAGE:  state <= S_DCHK;
              sdt_pkg::REQ_PRESENT: state <= S_PRD;
              default:              state <= S_DONE;
            endcase
          end
        end
        S_CRT: begin
          if (size_bad) begin
            res_status <= sdt_pkg::STAT_BAD_SIZE;
          end else if (!free_found) begin
            res_status <= sdt_pkg::STAT_FULL;
          end else begin
            used[free_idx]  <= 1'b1;
            dirty[free_idx] <= 1'b1;
            res_index       <= sdt_pkg::ID_W'(free_idx);
          end
          state <= S_DONE;
        end
        S_DCHK: begin
          if (!id_ok) begin
            res_status <= sdt_pkg::STAT_BAD_ID;
            state      <= S_DONE;
          end else begin
            state <= S_DUPD;
          end
        end
        S_DUPD: begin
          if (wr_en) begin
            dirty[id_idx] <= 1'b1;
          end else begin
            res_status <= sdt_pkg::STAT_OUTSIDE;
          end
          state <= S_DONE;
        end
        S_PRD: begin
          if (used[scan] && dirty[scan]) begin
            state <= S_PCHK;
          end else if (scan_last) begin
            counter <= counter + 1'b1;
            state   <= S_DONE;
          end else begin
            scan <= scan + 1'b1;
          end
        end
        S_PCHK: begin
          fold_word <= rd_data.color ^ dmg_w ^ dmg_h;
          fold_cnt  <= '0;
          state     <= S_PFOLD;
        end
        S_PFOLD: begin
          hash      <= sdt_pkg::fold_byte(hash, fold_word[7:0]);
          fold_word <= fold_word >> 8;
          fold_cnt  <= fold_cnt + 1'b1;
          if (fold_cnt == 2'd3) begin
            dirty[scan] <= 1'b0;
            if (scan_last) begin
              counter <= counter + 1'b1;
              state   <= S_DONE;
            end else begin
              scan  <= scan + 1'b1;
              state <= S_PRD;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid  <= 1'b1;
            out_status <= res_status;
            out_index  <= res_index;
            out_hash   <= (op == sdt_pkg::REQ_PRESENT) ? hash : '0;
            out_count  <= counter;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_dirty_needs_used: assert property (@(posedge clk) disable iff (rst)
    (dirty & ~used) == '0)
    else $error("dirty flag set on an unused entry");

  a_used_never_cleared: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> ((used & $past(used)) == $past(used)))
    else $error("used flag cleared");

  a_create_takes_one: assert property (@(posedge clk) disable iff (rst)
    (state == S_CRT) |=> ($countones(used) <= $countones($past(used)) + 1))
    else $error("create took more than one entry");

  a_present_leaves_clean: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DONE) && ($past(state) == S_PRD || $past(state) == S_PFOLD))
      |-> (dirty == '0))
    else $error("present finished with dirty entries");
`endif

endmodule

`default_nettype wire

// ----- dv/surface_damage_tracker_tb.sv -----
// Self-checking testbench for surface_damage_tracker: directed and random request traffic
// checked against a shadow copy of the surface table kept in the testbench.
// Depends on sdt_pkg, the channel interfaces in sdt_ifs.sv and the tracker RTL.
`timescale 1ns / 100ps

module surface_damage_tracker_tb;

  // The request field is two bits wide, so code 3 is legal on the wire but names no
  // operation. The block must answer it without touching any state.
  localparam logic [sdt_pkg::TYPE_W-1:0] REQ_UNKNOWN = 2'd3;

  typedef struct packed {
    logic [sdt_pkg::TYPE_W-1:0]  req_type;
    logic [sdt_pkg::ID_W-1:0]    surf_id;
    logic [sdt_pkg::DIM_W-1:0]   pos_x;
    logic [sdt_pkg::DIM_W-1:0]   pos_y;
    logic [sdt_pkg::DIM_W-1:0]   width;
    logic [sdt_pkg::DIM_W-1:0]   height;
    logic [sdt_pkg::COLOR_W-1:0] color;
  } req_item_t;

  typedef struct packed {
    logic [sdt_pkg::STATUS_W-1:0] status;
    logic [sdt_pkg::ID_W-1:0]     new_index;
    logic [sdt_pkg::HASH_W-1:0]   frame_hash;
    logic [sdt_pkg::COUNT_W-1:0]  frame_count;
  } rsp_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sdt_req_if req_ch ();
  sdt_rsp_if rsp_ch ();

  surface_damage_tracker u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Shadow of the surface table. It is updated at the moment a request transaction is
  // accepted. The block serves requests strictly in order, so the response owed for each
  // request can be computed right there and queued.
  logic                        shadow_used  [sdt_pkg::SURFACES];
  logic                        shadow_dirty [sdt_pkg::SURFACES];
  sdt_pkg::entry_t             shadow_entry [sdt_pkg::SURFACES];
  logic [sdt_pkg::COUNT_W-1:0] shadow_frames;
  rsp_item_t                   owed_rsp [$];

  int error_count = 0;

  // Idle percentages for the two sides. The test tasks change them from phase to phase.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  // Watchdog. A correct run needs well under a tenth of this time, even with every
  // present walking sixteen dirty entries and both sides idling heavily.
  initial begin
    #10ms;
    $display("Some tests failed");
    $finish;
  end

  // The receiver decides at every falling edge whether to stall the response channel
  // during the next cycle.
  always @(negedge clk) begin
    rsp_ch.ready = ($urandom_range(99) >= recv_stall_pct);
  end

  // Fold one 32-bit word into an FNV-1a hash, low byte first.
  function automatic logic [sdt_pkg::HASH_W-1:0] fnv_mix_word(
      input logic [sdt_pkg::HASH_W-1:0] h, input logic [31:0] v);
    logic [sdt_pkg::HASH_W-1:0] acc;
    acc = h;
    for (int b = 0; b < 4; b++) begin
      acc = acc ^ {24'd0, v[8*b +: 8]};
      acc = acc * sdt_pkg::FNV_PRIME;
    end
    return acc;
  endfunction

  // Apply one accepted request to the shadow table and return the response that the
  // block owes for it.
  function automatic rsp_item_t shadow_apply(input req_item_t it);
    rsp_item_t r;
    int ex;
    int ey;
    int id;
    logic [31:0] v;
    r = '0;
    id = it.surf_id;
    case (it.req_type)
      sdt_pkg::REQ_CREATE: begin
        if (it.width == 0 || it.height == 0 || it.width > sdt_pkg::MAX_DIM ||
            it.height > sdt_pkg::MAX_DIM) begin
          r.status = sdt_pkg::STAT_BAD_SIZE;
        end else begin
          // The table is full unless the scan finds a free entry. The lowest free
          // entry wins.
          r.status = sdt_pkg::STAT_FULL;
          for (int i = 0; i < sdt_pkg::SURFACES; i++) begin
            if (!shadow_used[i]) begin
              shadow_used[i] = 1'b1;
              shadow_dirty[i] = 1'b1;
              shadow_entry[i].color = it.color;
              shadow_entry[i].size_w = it.width;
              shadow_entry[i].size_h = it.height;
              shadow_entry[i].x0 = '0;
              shadow_entry[i].y0 = '0;
              shadow_entry[i].x1 = it.width;
              shadow_entry[i].y1 = it.height;
              r.status = sdt_pkg::STAT_OK;
              r.new_index = sdt_pkg::ID_W'(i);
              break;
            end
          end
        end
      end
      sdt_pkg::REQ_DAMAGE: begin
        if (id >= sdt_pkg::SURFACES || !shadow_used[id]) begin
          r.status = sdt_pkg::STAT_BAD_ID;
        end else if (it.pos_x >= shadow_entry[id].size_w ||
                     it.pos_y >= shadow_entry[id].size_h) begin
          r.status = sdt_pkg::STAT_OUTSIDE;
        end else begin
          // The far corner is clipped to the surface. It can exceed 13 bits before
          // the clip, so the sum is formed in int.
          ex = int'(it.pos_x) + int'(it.width);
          ey = int'(it.pos_y) + int'(it.height);
          if (ex > shadow_entry[id].size_w) ex = shadow_entry[id].size_w;
          if (ey > shadow_entry[id].size_h) ey = shadow_entry[id].size_h;
          if (!shadow_dirty[id]) begin
            shadow_entry[id].x0 = it.pos_x;
            shadow_entry[id].y0 = it.pos_y;
            shadow_entry[id].x1 = sdt_pkg::DIM_W'(ex);
            shadow_entry[id].y1 = sdt_pkg::DIM_W'(ey);
          end else begin
            // A dirty entry keeps the bounding box of its old and new damage.
            if (it.pos_x < shadow_entry[id].x0) shadow_entry[id].x0 = it.pos_x;
            if (it.pos_y < shadow_entry[id].y0) shadow_entry[id].y0 = it.pos_y;
            if (ex > shadow_entry[id].x1) shadow_entry[id].x1 = sdt_pkg::DIM_W'(ex);
            if (ey > shadow_entry[id].y1) shadow_entry[id].y1 = sdt_pkg::DIM_W'(ey);
          end
          // An empty rectangle after the clip still counts as damage.
          shadow_dirty[id] = 1'b1;
        end
      end
      sdt_pkg::REQ_PRESENT: begin
        r.frame_hash = sdt_pkg::FNV_BASIS;
        for (int i = 0; i < sdt_pkg::SURFACES; i++) begin
          if (shadow_used[i] && shadow_dirty[i]) begin
            v = shadow_entry[i].color ^ 32'(shadow_entry[i].x1 - shadow_entry[i].x0)
                ^ 32'(shadow_entry[i].y1 - shadow_entry[i].y0);
            r.frame_hash = fnv_mix_word(r.frame_hash, v);
            shadow_dirty[i] = 1'b0;
          end
        end
        shadow_frames = shadow_frames + 1'b1;
      end
      default: begin
      end
    endcase
    r.frame_count = shadow_frames;
    return r;
  endfunction

  // Check every response transaction against the oldest response still owed.
  always @(posedge clk) begin : rsp_check
    rsp_item_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (owed_rsp.size() == 0) begin
        $error("response transaction with no request outstanding");
        error_count++;
      end else begin
        want = owed_rsp.pop_front();
        if (rsp_ch.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
          error_count++;
        end
        if (rsp_ch.new_index !== want.new_index) begin
          $error("new_index: expected %0d, got %0d", want.new_index, rsp_ch.new_index);
          error_count++;
        end
        if (rsp_ch.frame_hash !== want.frame_hash) begin
          $error("frame_hash: expected %h, got %h", want.frame_hash, rsp_ch.frame_hash);
          error_count++;
        end
        if (rsp_ch.frame_count !== want.frame_count) begin
          $error("frame_count: expected %0d, got %0d", want.frame_count,
                 rsp_ch.frame_count);
          error_count++;
        end
      end
    end
  end

  // Send one request. The task is entered and left at a falling edge. The sender may idle
  // first, then holds valid until a rising edge finds ready high. The shadow table is
  // updated at that edge.
  task automatic send_request(input req_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid = 1'b0;
      @(negedge clk);
    end
    req_ch.req_type = it.req_type;
    req_ch.surf_id = it.surf_id;
    req_ch.pos_x = it.pos_x;
    req_ch.pos_y = it.pos_y;
    req_ch.width = it.width;
    req_ch.height = it.height;
    req_ch.color = it.color;
    req_ch.valid = 1'b1;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    owed_rsp.push_back(shadow_apply(it));
    @(negedge clk);
    req_ch.valid = 1'b0;
  endtask

  // Hold off until every owed response has come back.
  task automatic wait_drained();
    while (owed_rsp.size() != 0) @(negedge clk);
  endtask

  function automatic req_item_t make_req(input logic [sdt_pkg::TYPE_W-1:0] kind,
                                         input int id, input int x, input int y,
                                         input int w, input int h,
                                         input logic [sdt_pkg::COLOR_W-1:0] color);
    req_item_t it;
    it.req_type = kind;
    it.surf_id = sdt_pkg::ID_W'(id);
    it.pos_x = sdt_pkg::DIM_W'(x);
    it.pos_y = sdt_pkg::DIM_W'(y);
    it.width = sdt_pkg::DIM_W'(w);
    it.height = sdt_pkg::DIM_W'(h);
    it.color = color;
    return it;
  endfunction

  // Draw one random request. Most are damage requests aimed at live surfaces with an
  // origin inside them. Creates are kept rare so that the table fills only partway through
  // the run. The rest are presents, unknown codes and fully random noise.
  function automatic req_item_t random_request();
    req_item_t it;
    int live [$];
    int pick;
    int lim_w;
    int lim_h;
    it.req_type = REQ_UNKNOWN;
    it.surf_id = sdt_pkg::ID_W'($urandom_range(15));
    it.pos_x = sdt_pkg::DIM_W'($urandom_range(8191));
    it.pos_y = sdt_pkg::DIM_W'($urandom_range(8191));
    it.width = sdt_pkg::DIM_W'($urandom_range(8191));
    it.height = sdt_pkg::DIM_W'($urandom_range(8191));
    it.color = $urandom;
    pick = $urandom_range(99);
    if (pick < 5) begin
      it.req_type = sdt_pkg::REQ_CREATE;
      // One create in five keeps its fully random, often oversized, dimensions.
      if ($urandom_range(4) != 0) begin
        it.width = sdt_pkg::DIM_W'($urandom_range(1) ? $urandom_range(64, 1)
                                                      : $urandom_range(4096, 1));
        it.height = sdt_pkg::DIM_W'($urandom_range(1) ? $urandom_range(64, 1)
                                                       : $urandom_range(4096, 1));
      end
    end else if (pick < 75) begin
      it.req_type = sdt_pkg::REQ_DAMAGE;
      for (int i = 0; i < sdt_pkg::SURFACES; i++) begin
        if (shadow_used[i]) live.push_back(i);
      end
      if (live.size() > 0 && $urandom_range(99) < 85) begin
        it.surf_id = sdt_pkg::ID_W'(live[$urandom_range(live.size() - 1)]);
      end
      if (shadow_used[it.surf_id]) begin
        lim_w = shadow_entry[it.surf_id].size_w;
        lim_h = shadow_entry[it.surf_id].size_h;
        if ($urandom_range(3) != 0) begin
          it.pos_x = sdt_pkg::DIM_W'($urandom_range(lim_w - 1, 0));
          it.pos_y = sdt_pkg::DIM_W'($urandom_range(lim_h - 1, 0));
        end
        // Small rectangles, rectangles up to the surface size, or anything at all.
        case ($urandom_range(4))
          0, 1: begin
            it.width = sdt_pkg::DIM_W'($urandom_range(15));
            it.height = sdt_pkg::DIM_W'($urandom_range(15));
          end
          2, 3: begin
            it.width = sdt_pkg::DIM_W'($urandom_range(lim_w, 0));
            it.height = sdt_pkg::DIM_W'($urandom_range(lim_h, 0));
          end
          default: begin
          end
        endcase
      end
    end else if (pick < 92) begin
      it.req_type = sdt_pkg::REQ_PRESENT;
    end else if (pick >= 95) begin
      it.req_type = sdt_pkg::TYPE_W'($urandom_range(3));
    end
    return it;
  endfunction

  // Create requests with each bad dimension, then three good surfaces: the largest
  // allowed, the smallest, and an ordinary one. They land in entries 0, 1 and 2.
  task automatic test_create_sizes();
    send_request(make_req(sdt_pkg::REQ_CREATE, 0, 0, 0, 0, 5, 32'h1234_5678));
    send_request(make_req(sdt_pkg::REQ_CREATE, 0, 0, 0, 5, 0, 32'h1234_5678));
    send_request(make_req(sdt_pkg::REQ_CREATE, 0, 0, 0, sdt_pkg::MAX_DIM + 1, 10, 32'h0));
    send_request(make_req(sdt_pkg::REQ_CREATE, 0, 0, 0, 10, 8191, 32'hFFFF_FFFF));
    send_request(make_req(sdt_pkg::REQ_CREATE, 0, 0, 0, sdt_pkg::MAX_DIM, sdt_pkg::MAX_DIM,
                          32'hFFFF_FFFF));
    send_request(make_req(sdt_pkg::REQ_CREATE, 0, 0, 0, 1, 1, 32'h0));
    send_request(make_req(sdt_pkg::REQ_CREATE, 0, 0, 0, 100, 60, 32'h5A5A_A5A5));
  endtask

  // Damage requests that fail the id or origin checks, then requests that pass and merge
  // into entries that are still dirty from their create. One of them is clipped from the
  // largest fields, and one has an empty width. A present then hashes the result.
  task automatic test_damage_checks();
    send_request(make_req(sdt_pkg::REQ_DAMAGE, 15, 0, 0, 1, 1, 32'h0));
    send_request(make_req(sdt_pkg::REQ_DAMAGE, 1, 1, 0, 1, 1, 32'h0));
    send_request(make_req(sdt_pkg::REQ_DAMAGE, 1, 0, 1, 1, 1, 32'h0));
    send_request(make_req(sdt_pkg::REQ_DAMAGE, 0, 8191, 0, 1, 1, 32'h0));
    send_request(make_req(sdt_pkg::REQ_DAMAGE, 0, 4095, 4095, 8191, 8191, 32'hFFFF_FFFF));
    send_request(make_req(sdt_pkg::REQ_DAMAGE, 2, 10, 10, 0, 5, 32'h0));
    send_request(make_req(sdt_pkg::REQ_PRESENT, 0, 0, 0, 0, 0, 32'h0));
  endtask

  // Present with no dirty entry, damage that replaces a clean rectangle and then grows it
  // with clipping, empty damage on a clean entry, and an unknown request with every field
  // set. Before the second present the sender waits for all responses to drain.
  task automatic test_present();
    send_request(make_req(sdt_pkg::REQ_PRESENT, 0, 0, 0, 0, 0, 32'h0));
    send_request(make_req(sdt_pkg::REQ_DAMAGE, 2, 5, 7, 3, 4, 32'h0));
    send_request(make_req(sdt_pkg::REQ_DAMAGE, 2, 50, 1, 100, 2, 32'h0));
    send_request(make_req(sdt_pkg::REQ_DAMAGE, 1, 0, 0, 0, 0, 32'h0));
    wait_drained();
    send_request(make_req(sdt_pkg::REQ_PRESENT, 0, 0, 0, 0, 0, 32'h0));
    send_request(make_req(REQ_UNKNOWN, 15, 8191, 8191, 8191, 8191, 32'hFFFF_FFFF));
  endtask

  // Random traffic in four idling phases: no idling, a sender idle about half the time,
  // a receiver stalling about half the time, and both sides idling.
  task automatic test_random_traffic();
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 53;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 53;
        end
        default: begin
          send_idle_pct = 38;
          recv_stall_pct = 38;
        end
      endcase
      repeat (135) send_request(random_request());
    end
  endtask

  // Fill any entries still free, then show that one more create is refused. A bad size
  // is still reported as a bad size when the table is full. A last present hashes
  // whatever is still dirty.
  task automatic test_table_full();
    for (int i = 0; i < sdt_pkg::SURFACES; i++) begin
      if (!shadow_used[i]) begin
        send_request(make_req(sdt_pkg::REQ_CREATE, 0, 0, 0, 1 + i, 2 + i, $urandom));
      end
    end
    send_request(make_req(sdt_pkg::REQ_CREATE, 0, 0, 0, 7, 9, 32'hDEAD_BEEF));
    send_request(make_req(sdt_pkg::REQ_CREATE, 0, 0, 0, 0, 9, 32'hDEAD_BEEF));
    send_request(make_req(sdt_pkg::REQ_PRESENT, 0, 0, 0, 0, 0, 32'h0));
  endtask

  initial begin
    req_ch.valid = 1'b0;
    req_ch.req_type = sdt_pkg::REQ_CREATE;
    req_ch.surf_id = '0;
    req_ch.pos_x = '0;
    req_ch.pos_y = '0;
    req_ch.width = '0;
    req_ch.height = '0;
    req_ch.color = '0;
    rsp_ch.ready = 1'b0;
    for (int i = 0; i < sdt_pkg::SURFACES; i++) begin
      shadow_used[i] = 1'b0;
      shadow_dirty[i] = 1'b0;
      shadow_entry[i] = '0;
    end
    shadow_frames = '0;

    repeat (12) @(negedge clk);
    rst = 1'b0;

    test_create_sizes();
    test_damage_checks();
    test_present();
    test_random_traffic();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_table_full();

    // After the last owed response, wait longer than a present over sixteen dirty entries
    // takes, so that any stray response transaction is still caught.
    wait_drained();
    repeat (120) @(posedge clk);
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/sdt_pkg.sv
sv/sdt_ifs.sv
sv/surface_damage_tracker.sv
dv/surface_damage_tracker_tb.sv
